@@ rtl/core/trm_pkg.sv @@
`default_nettype none

package trm_pkg;

    // register indexes on the configuration port
    localparam logic [7:0] REG_TICKS_PER_SECOND = 8'd0;
    localparam logic [7:0] REG_ZERO_LIMIT       = 8'd1;
    localparam logic [7:0] REG_COUNT_LIMIT      = 8'd2;
    localparam logic [7:0] REG_UNIT_SELECT      = 8'd3;

    // reset values of the registers
    localparam logic [9:0]  TPS_RESET        = 10'd2;
    localparam logic [7:0]  ZERO_LIMIT_RESET = 8'd20;
    localparam logic [15:0] COUNT_LIM_RESET  = 16'd1000;

    // unit codes
    localparam logic [1:0] UNIT_BYTES = 2'd0;
    localparam logic [1:0] UNIT_KIB   = 2'd1;
    localparam logic [1:0] UNIT_MIB   = 2'd2;
    localparam logic [1:0] UNIT_RESET = UNIT_BYTES;

    localparam int KIB_SHIFT = 10;
    localparam int MIB_SHIFT = 20;

    // divider steps, one quotient bit each
    localparam logic [5:0] DIV_LAST_STEP = 6'd63;

    typedef struct packed {
        logic [63:0] rx_total;
        logic [63:0] tx_total;
    } t_in;

    typedef struct packed {
        logic        speed_valid;
        logic [63:0] rx_speed;
        logic [63:0] tx_speed;
        logic [63:0] rx_average;
        logic [63:0] tx_average;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SPD,
        S_UPD,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic spd;
        logic upd;
        logic div_load;
        logic div_step;
        logic div_store;
        logic out_load;
        logic dir;       // 0 receive, 1 transmit
    } t_cmd;

    typedef struct packed {
        logic div_skip;  // sample count or sum is zero: average is zero
    } t_sts;

    function automatic logic [63:0] scale_unit(input logic [63:0] q, input logic [1:0] unit);
        logic [63:0] r;
        case (unit)
            UNIT_BYTES: r = q;
            UNIT_KIB:   r = q >> KIB_SHIFT;
            UNIT_MIB:   r = q >> MIB_SHIFT;
            default:    r = 64'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/trm_ctrl.sv @@
`default_nettype none

module trm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_out_stall,
    input  trm_pkg::t_sts     i_sts,
    output trm_pkg::t_cmd     o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    trm_pkg::t_state r_state;
    trm_pkg::t_state n_state;
    logic            r_dir;
    logic            n_dir;
    logic [5:0]      r_step;
    logic [5:0]      n_step;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_accept;
    logic            w_out_free;

    assign o_in_stall  = (r_state != trm_pkg::S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            trm_pkg::S_IDLE: begin
                if (w_accept) n_state = trm_pkg::S_MUL;
            end
            trm_pkg::S_MUL: n_state = trm_pkg::S_SPD;
            trm_pkg::S_SPD: n_state = trm_pkg::S_UPD;
            trm_pkg::S_UPD: begin
                n_state = r_dir ? trm_pkg::S_DIV_LOAD : trm_pkg::S_MUL;
            end
            trm_pkg::S_DIV_LOAD: begin
                n_state = i_sts.div_skip ? trm_pkg::S_DIV_STORE : trm_pkg::S_DIV_RUN;
            end
            trm_pkg::S_DIV_RUN: begin
                if (r_step == trm_pkg::DIV_LAST_STEP) n_state = trm_pkg::S_DIV_STORE;
            end
            trm_pkg::S_DIV_STORE: begin
                n_state = r_dir ? trm_pkg::S_OUT : trm_pkg::S_DIV_LOAD;
            end
            trm_pkg::S_OUT: begin
                if (w_out_free) n_state = trm_pkg::S_IDLE;
            end
            default: n_state = trm_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.dir      = r_dir;
        o_cmd.load_in  = w_accept;
        case (r_state)
            trm_pkg::S_MUL:       o_cmd.mul       = 1'b1;
            trm_pkg::S_SPD:       o_cmd.spd       = 1'b1;
            trm_pkg::S_UPD:       o_cmd.upd       = 1'b1;
            trm_pkg::S_DIV_LOAD:  o_cmd.div_load  = 1'b1;
            trm_pkg::S_DIV_RUN:   o_cmd.div_step  = 1'b1;
            trm_pkg::S_DIV_STORE: o_cmd.div_store = 1'b1;
            trm_pkg::S_OUT:       o_cmd.out_load  = w_out_free;
            default:              o_cmd.dir       = r_dir;
        endcase
    end

    // direction, step count, result valid
    always_comb begin
        n_dir = r_dir;
        if (w_accept) begin
            n_dir = 1'b0;
        end else if (r_state == trm_pkg::S_UPD || r_state == trm_pkg::S_DIV_STORE) begin
            n_dir = !r_dir;
        end
        n_step = (r_state == trm_pkg::S_DIV_RUN) ? r_step + 6'd1 : 6'd0;
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trm_pkg::S_IDLE;
            r_dir       <= 1'b0;
            r_step      <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/trm_datapath.sv @@
`default_nettype none

module trm_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [7:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data,
    input  trm_pkg::t_in      i_in_data,
    input  trm_pkg::t_cmd     i_cmd,
    output trm_pkg::t_sts     o_sts,
    output trm_pkg::t_out     o_out_data
);

    // configuration
    logic [9:0]  r_tps;
    logic [7:0]  r_zero_limit;
    logic [15:0] r_count_limit;
    logic [1:0]  r_unit;

    // tick state and history
    logic        r_first;
    logic [63:0] r_last_rx;
    logic [63:0] r_last_tx;
    logic [16:0] r_cnt  [2];
    logic [63:0] r_sum  [2];
    logic [8:0]  r_idle [2];

    // working registers
    logic [63:0] r_in_rx;
    logic [63:0] r_in_tx;
    logic [41:0] r_pp_lo;
    logic [41:0] r_pp_hi;
    logic [63:0] r_rx_spd;
    logic [63:0] r_tx_spd;
    logic [63:0] r_rx_avg;
    logic [63:0] r_tx_avg;
    logic [63:0] r_quo;
    logic [16:0] r_rem;
    logic [16:0] r_dvs;
    trm_pkg::t_out r_out;

    logic        w_d;
    logic [63:0] w_delta;
    logic [73:0] w_prod;
    logic [63:0] w_spd;
    logic [63:0] w_spd_cur;
    logic [8:0]  w_idle_inc;
    logic        w_cnt_over;
    logic [16:0] w_cnt_base;
    logic [63:0] w_sum_base;
    logic [64:0] w_sum_add;
    logic [17:0] w_shift;
    logic [17:0] w_trial;

    assign w_d       = i_cmd.dir;
    assign w_delta   = w_d ? (r_in_tx - r_last_tx) : (r_in_rx - r_last_rx);
    assign w_prod    = {r_pp_hi, 32'd0} + {32'd0, r_pp_lo};
    // saturate when the product spills past 64 bits
    assign w_spd     = r_first ? 64'd0 : ((|w_prod[73:64]) ? '1 : w_prod[63:0]);
    assign w_spd_cur = w_d ? r_tx_spd : r_rx_spd;

    assign w_idle_inc = r_idle[w_d] + 9'd1;
    assign w_cnt_over = r_cnt[w_d] > {1'b0, r_count_limit};
    assign w_cnt_base = w_cnt_over ? 17'd0 : r_cnt[w_d];
    assign w_sum_base = w_cnt_over ? 64'd0 : r_sum[w_d];
    assign w_sum_add  = {1'b0, w_sum_base} + {1'b0, w_spd_cur};

    assign w_shift = {r_rem, r_quo[63]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    assign o_sts.div_skip = (r_cnt[w_d] == 17'd0) || (r_sum[w_d] == 64'd0);
    assign o_out_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps         <= trm_pkg::TPS_RESET;
            r_zero_limit  <= trm_pkg::ZERO_LIMIT_RESET;
            r_count_limit <= trm_pkg::COUNT_LIM_RESET;
            r_unit        <= trm_pkg::UNIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                trm_pkg::REG_TICKS_PER_SECOND: r_tps         <= i_cfg_data[9:0];
                trm_pkg::REG_ZERO_LIMIT:       r_zero_limit  <= i_cfg_data[7:0];
                trm_pkg::REG_COUNT_LIMIT:      r_count_limit <= i_cfg_data;
                trm_pkg::REG_UNIT_SELECT:      r_unit        <= i_cfg_data[1:0];
                default:                       r_unit        <= r_unit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_last_rx <= 64'd0;
            r_last_tx <= 64'd0;
            r_cnt[0]  <= 17'd0;
            r_cnt[1]  <= 17'd0;
            r_sum[0]  <= 64'd0;
            r_sum[1]  <= 64'd0;
            r_idle[0] <= 9'd0;
            r_idle[1] <= 9'd0;
        end else begin
            if (i_cmd.upd && !r_first) begin
                if (w_spd_cur == 64'd0) begin
                    if (w_idle_inc > {1'b0, r_zero_limit}) begin
                        r_cnt[w_d]  <= 17'd0;
                        r_sum[w_d]  <= 64'd0;
                        r_idle[w_d] <= 9'd0;
                    end else begin
                        r_idle[w_d] <= w_idle_inc;
                    end
                end else begin
                    r_cnt[w_d]  <= w_cnt_base + 17'd1;
                    r_sum[w_d]  <= w_sum_add[64] ? '1 : w_sum_add[63:0];
                    r_idle[w_d] <= 9'd0;
                end
            end
            if (i_cmd.out_load) begin
                r_first   <= 1'b0;
                r_last_rx <= r_in_rx;
                r_last_tx <= r_in_tx;
            end
        end
    end

    // payload path, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_rx <= i_in_data.rx_total;
            r_in_tx <= i_in_data.tx_total;
        end
        if (i_cmd.mul) begin
            r_pp_lo <= w_delta[31:0] * r_tps;
            r_pp_hi <= w_delta[63:32] * r_tps;
        end
        if (i_cmd.spd) begin
            if (w_d) r_tx_spd <= w_spd;
            else     r_rx_spd <= w_spd;
        end
        if (i_cmd.div_load) begin
            r_quo <= o_sts.div_skip ? 64'd0 : r_sum[w_d];
            r_rem <= 17'd0;
            r_dvs <= r_cnt[w_d];
        end else if (i_cmd.div_step) begin
            if (!w_trial[17]) begin
                r_rem <= w_trial[16:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift[16:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            if (w_d) r_tx_avg <= trm_pkg::scale_unit(r_quo, r_unit);
            else     r_rx_avg <= trm_pkg::scale_unit(r_quo, r_unit);
        end
        if (i_cmd.out_load) begin
            r_out.speed_valid <= !r_first;
            r_out.rx_speed    <= r_rx_spd;
            r_out.tx_speed    <= r_tx_spd;
            r_out.rx_average  <= r_rx_avg;
            r_out.tx_average  <= r_tx_avg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/traffic_rate_meter_with_average.sv @@
`default_nettype none

// Traffic rate meter. Each input request is one sample tick carrying the summed
// receive and transmit byte counters; each tick yields exactly one result with
// both speeds (counter delta times ticks per second, saturated at 2^64-1) and
// both running averages (history sum / sample count, scaled to the selected
// unit). The first tick after reset only records the counters: speed_valid is
// 0 and speeds are 0. A tick runs the speed and history update for receive,
// then for transmit, then one 64-step division per direction whose history
// is nonzero, then loads the result register; a new tick is taken only once
// that load is done. The divisions share one radix-2 divider (one quotient
// bit per cycle). A new tick is accepted while the previous result still
// waits in the output register. Configuration writes are always ready
// and should only be issued while no tick is in flight.
module traffic_rate_meter_with_average (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // tick input
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  trm_pkg::t_in      i_in_data,
    // result output
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output trm_pkg::t_out     o_out_data,
    // configuration writes
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [7:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data
);

    trm_pkg::t_cmd w_cmd;
    trm_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // sequencer: speed and history update for rx then tx, then the two divisions
    trm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // registers, shared multiplier pair, history and divider
    trm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

    // once a tick is taken, no other is taken until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("tick accepted while previous tick in flight");

    // a result only appears after the sequencer has loaded one
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result valid without a load");

    // no speeds are reported for the recording tick
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.speed_valid) |->
            (o_out_data.rx_speed == 64'd0 && o_out_data.tx_speed == 64'd0))
        else $error("nonzero speed on recording tick");

endmodule

`default_nettype wire

@@ tb/tb_traffic_rate_meter_with_average.sv @@
`default_nettype none

module tb_traffic_rate_meter_with_average;
    timeunit 1ns;
    timeprecision 1ps;

    // unit code the block leaves unused: averages read as zero
    localparam logic [1:0] UNIT_UNUSED = 2'd3;
    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 700;   // long receiver hold-off for backpressure
    localparam int DRAIN_CYCLES   = 150;   // one full tick with two divisions, plus margin
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake of any kind

    // ------------------------------------------------------------------
    // Rate/average tracker: mirrors the block's history per direction
    // (index 0 receive, 1 transmit) and keeps the results still owed.
    // ------------------------------------------------------------------
    class meter_tracker;
        logic [9:0]  tps;
        logic [7:0]  zlim;
        logic [15:0] clim;
        logic [1:0]  unit;
        bit          first_tick;
        logic [63:0] last_rx, last_tx;
        logic [16:0] samples [2];
        logic [63:0] speed_total [2];
        logic [8:0]  idle_run [2];
        trm_pkg::t_out owed_ticks [$];
        int          errors;
        int          checked;

        function new();
            tps        = trm_pkg::TPS_RESET;
            zlim       = trm_pkg::ZERO_LIMIT_RESET;
            clim       = trm_pkg::COUNT_LIM_RESET;
            unit       = trm_pkg::UNIT_RESET;
            first_tick = 1'b1;
            last_rx    = '0;
            last_tx    = '0;
            errors     = 0;
            checked    = 0;
            wipe_history(0);
            wipe_history(1);
        endfunction

        function void wipe_history(int d);
            samples[d]     = '0;
            speed_total[d] = '0;
            idle_run[d]    = '0;
        endfunction

        // register write as the block applies it: masked to width, unknown index dropped
        function void write_reg(logic [7:0] idx, logic [15:0] val);
            case (idx)
                trm_pkg::REG_TICKS_PER_SECOND: tps  = val[9:0];
                trm_pkg::REG_ZERO_LIMIT:       zlim = val[7:0];
                trm_pkg::REG_COUNT_LIMIT:      clim = val[15:0];
                trm_pkg::REG_UNIT_SELECT:      unit = val[1:0];
                default: ;
            endcase
        endfunction

        // counter delta (wrapping) times ticks per second, saturated
        function logic [63:0] rate_of(logic [63:0] now, logic [63:0] prev);
            logic [63:0] delta;
            logic [73:0] prod;
            delta = now - prev;
            prod  = delta * tps;
            if (prod[73:64] != '0)
                return '1;
            return prod[63:0];
        endfunction

        function void fold_speed(int d, logic [63:0] v);
            logic [64:0] acc;
            if (v == '0) begin
                idle_run[d] = idle_run[d] + 1'b1;
                if (idle_run[d] > zlim)
                    wipe_history(d);
                return;
            end
            if (samples[d] > clim)
                wipe_history(d);
            samples[d] = samples[d] + 1'b1;
            acc = speed_total[d] + v;
            speed_total[d] = acc[64] ? '1 : acc[63:0];
            idle_run[d] = '0;
        endfunction

        function logic [63:0] mean_of(int d);
            logic [63:0] q;
            if (samples[d] == '0 || speed_total[d] == '0)
                return '0;
            q = speed_total[d] / samples[d];
            case (unit)
                trm_pkg::UNIT_BYTES: return q;
                trm_pkg::UNIT_KIB:   return q >> trm_pkg::KIB_SHIFT;
                trm_pkg::UNIT_MIB:   return q >> trm_pkg::MIB_SHIFT;
                default:             return '0;
            endcase
        endfunction

        // accepted tick request: work out the one result it owes
        function void predict_tick(trm_pkg::t_in req);
            trm_pkg::t_out e;
            e = '0;
            if (!first_tick) begin
                e.speed_valid = 1'b1;
                e.rx_speed    = rate_of(req.rx_total, last_rx);
                fold_speed(0, e.rx_speed);
                e.tx_speed    = rate_of(req.tx_total, last_tx);
                fold_speed(1, e.tx_speed);
            end else begin
                first_tick = 1'b0;
            end
            last_rx      = req.rx_total;
            last_tx      = req.tx_total;
            e.rx_average = mean_of(0);
            e.tx_average = mean_of(1);
            owed_ticks.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_tick(trm_pkg::t_out got);
            trm_pkg::t_out e;
            if (owed_ticks.size() == 0) begin
                errors++;
                $display("%0t: result with nothing owed, actual %h", $time, got);
                return;
            end
            e = owed_ticks.pop_front();
            checked++;
            compare_field("speed_valid", e.speed_valid, got.speed_valid);
            compare_field("rx_speed",    e.rx_speed,    got.rx_speed);
            compare_field("tx_speed",    e.tx_speed,    got.tx_speed);
            compare_field("rx_average",  e.rx_average,  got.rx_average);
            compare_field("tx_average",  e.tx_average,  got.tx_average);
        endfunction

        function int outstanding();
            return owed_ticks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    trm_pkg::t_in  i_in_data   = '0;
    logic          i_out_stall = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic [7:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data  = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    trm_pkg::t_out o_out_data;
    logic          o_cfg_ready;

    traffic_rate_meter_with_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    meter_tracker tracker;

    int          in_idle_pct   = 0;   // sender: chance of a pause after each request
    int          out_stall_pct = 0;   // receiver: chance of stall per cycle
    int          hold_kicks    = 0;   // bumped by the stimulus to ask for a hold-off
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          ticks_sent    = 0;
    int          reg_writes    = 0;
    logic [63:0] rx_now        = '0;  // running byte counters fed to the block
    logic [63:0] tx_now        = '0;
    int          rx_idle_burst = 0;   // pending zero-delta ticks per direction
    int          tx_idle_burst = 0;

    // ------------------------------------------------------------------
    // Receiver: checks every accepted result, stalls at random, and does
    // the long hold-off on request, counting it down here.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            tracker.check_tick(o_out_data);
        if (hold_seen != hold_kicks) begin
            hold_seen = hold_kicks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Watchdog: any handshake resets the quiet count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks; all called right after a rising edge
    // ------------------------------------------------------------------

    // Offer one tick and hold it until taken. Valid stays high into the
    // next request unless a pause is drawn.
    task automatic offer_tick(input trm_pkg::t_in req);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        tracker.predict_tick(req);
        ticks_sent++;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            // now and then a pause long enough to land anywhere in a division
            gap = ($urandom_range(9) == 0) ? $urandom_range(160, 1) : 1;
            while ($urandom_range(99) < in_idle_pct)
                gap++;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic tick_at(input logic [63:0] rx, input logic [63:0] tx);
        trm_pkg::t_in req;
        rx_now = rx;
        tx_now = tx;
        req.rx_total = rx;
        req.tx_total = tx;
        offer_tick(req);
    endtask

    // Register write; valid stays high when another write follows directly
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
        tracker.write_reg(idx, val);
        reg_writes++;
    endtask

    // Stop offering and wait until every owed result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Full register set; a write to an unmapped index goes first and must be ignored
    task automatic apply_setup(input logic [15:0] tps, input logic [15:0] zl,
                               input logic [15:0] cl, input logic [15:0] unit);
        write_reg({6'h3F, 2'($urandom_range(3))}, 16'($urandom()), 1'b0);
        write_reg(trm_pkg::REG_TICKS_PER_SECOND, tps, 1'b0);
        write_reg(trm_pkg::REG_ZERO_LIMIT, zl, 1'b0);
        write_reg(trm_pkg::REG_COUNT_LIMIT, cl, 1'b0);
        write_reg(trm_pkg::REG_UNIT_SELECT, unit, 1'b1);
    endtask

    // Counter increment for one direction: idle stretches, small, medium and
    // huge deltas; a full-width delta also makes the counter go backwards.
    function automatic logic [63:0] pick_delta(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return '0;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            burst = $urandom_range(24, 1);
            return '0;
        end
        if (r < 22)
            return '0;
        if (r < 60)
            return 64'($urandom_range(5000));
        if (r < 85)
            return {32'd0, $urandom()};
        if (r < 95)
            return {$urandom(), $urandom()} >> $urandom_range(63);
        return {$urandom(), $urandom()};
    endfunction

    function automatic trm_pkg::t_in next_tick();
        trm_pkg::t_in req;
        rx_now = rx_now + pick_delta(rx_idle_burst);
        tx_now = tx_now + pick_delta(tx_idle_burst);
        req.rx_total = rx_now;
        req.tx_total = tx_now;
        return req;
    endfunction

    task automatic run_phase(input logic [15:0] tps, input logic [15:0] zl,
                             input logic [15:0] cl, input logic [15:0] unit,
                             input int idle_pct, input int stall_pct, input int count);
        drain();
        apply_setup(tps, zl, cl, unit);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        repeat (count)
            offer_tick(next_tick());
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: high rate, zero and count limits both 1
        apply_setup(16'd1000, 16'd1, 16'd1, {14'd0, trm_pkg::UNIT_BYTES});
        tick_at('1, '1);                               // first tick only records
        tick_at('0, '0);                               // counters wrap back to zero
        tick_at('0, 64'd5);                            // rx idle
        tick_at('0, 64'd5);                            // rx idle past limit: cleared
        tick_at('0, 64'd5);                            // tx idle past limit: cleared
        tick_at(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);  // speeds saturate
        tick_at(64'h8000_0000_0000_0001, 64'h4000_0000_0000_0001);  // sums saturate
        tick_at(64'h8000_0000_0000_0002, 64'h4000_0000_0000_0002);  // count over limit
        tick_at(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        tick_at(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        // zero ticks per second (written with only the dropped bit set)
        drain();
        write_reg(trm_pkg::REG_UNIT_SELECT, {14'd0, trm_pkg::UNIT_KIB}, 1'b0);
        write_reg(trm_pkg::REG_TICKS_PER_SECOND, 16'h0400, 1'b1);
        tick_at(rx_now + 64'd7, tx_now + 64'd7);
        tick_at(rx_now + 64'd9, '0);

        // MiB scaling with loose limits
        drain();
        apply_setup(16'd1, 16'd255, 16'hFFFF, {14'h3FFF, trm_pkg::UNIT_MIB});
        tick_at(rx_now + (64'd1 << 40), tx_now + (64'd1 << 30));
        tick_at(rx_now + (64'd1 << 41), tx_now + 64'd3);

        // unused unit code: averages read zero
        drain();
        write_reg(trm_pkg::REG_UNIT_SELECT, 16'hFFFF, 1'b1);
        tick_at(rx_now + 64'd100, tx_now + 64'd200);
        tick_at(rx_now, tx_now);

        // Random phases: register extremes and masking, each idling mix
        run_phase(16'hFC01, 16'hFF00, 16'd1, {14'd0, trm_pkg::UNIT_BYTES}, 0, 0, 150);
        run_phase(16'd1000, 16'd255, 16'hFFFF, {14'h3FFF, trm_pkg::UNIT_KIB}, 56, 0, 150);
        run_phase(16'd7, 16'd3, 16'd5, {14'd0, trm_pkg::UNIT_MIB}, 0, 56, 150);
        run_phase(16'd2, 16'd20, 16'd1000, {14'd0, UNIT_UNUSED}, 18, 18, 150);
        run_phase(16'h0400, 16'd1, 16'd2, {14'd0, trm_pkg::UNIT_BYTES}, 18, 18, 150);
        run_phase(16'd512, 16'd8, 16'd64, {14'd0, trm_pkg::UNIT_KIB}, 56, 0, 150);
        run_phase(16'd1000, 16'd2, 16'd3, {14'd0, trm_pkg::UNIT_MIB}, 0, 56, 150);

        // Backpressure: receiver holds off while the sender keeps requesting
        drain();
        apply_setup(16'd3, 16'd5, 16'd10, {14'd0, trm_pkg::UNIT_BYTES});
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_kicks++;
        repeat (24)
            offer_tick(next_tick());

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d tick requests, %0d results checked, %0d register writes",
                 ticks_sent, tracker.checked, reg_writes);
        $display("Covered rate limits, idle/count history clears, saturation, units, stalls");
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/trm_pkg.sv
rtl/core/trm_ctrl.sv
rtl/core/trm_datapath.sv
rtl/core/traffic_rate_meter_with_average.sv
tb/tb_traffic_rate_meter_with_average.sv
